FILE: src/plp_pkg.sv
// Package for the pooled linked list engine: command kinds, result status
// codes, and the command/status structs between controller and datapath.
// No dependencies.
package plp_pkg;

    // Most results one read command may return
    localparam int MAX_RESULTS = 32;

    // Command kinds carried on the input tuser
    typedef enum logic [3:0] {
        K_INS_HEAD  = 4'd0,
        K_INS_TAIL  = 4'd1,
        K_INS_AT    = 4'd2,
        K_DEL_HEAD  = 4'd3,
        K_DEL_TAIL  = 4'd4,
        K_DEL_AT    = 4'd5,
        K_DEL_VALUE = 4'd6,
        K_UPD_AT    = 4'd7,
        K_UPD_VALUE = 4'd8,
        K_SEARCH    = 4'd9,
        K_READ      = 4'd10,
        K_CLEAR     = 4'd11
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Source of the next link written into a freshly allocated node
    typedef enum logic [1:0] {
        NL_HEAD = 2'd0,
        NL_NIL  = 2'd1,
        NL_HIT  = 2'd2
    } t_new_link;

    // Controller to datapath
    typedef struct packed {
        logic      cap;        // capture input beat
        logic      walk_init;  // cur = head, prev = nil, cnt = 0
        logic      rd_node;    // read value and link of cur
        logic      step;       // advance walk to next node
        logic      alloc_rd;   // pop free stack (read)
        logic      take_free;  // new node = popped entry
        logic      take_fresh; // new node = fresh mark
        logic      wr_new;     // write new node
        t_new_link nl_sel;
        logic      head_to_new;
        logic      link_new;   // link new node after cur or prev
        logic      unlink;     // drop cur from list and push it free
        logic      upd;        // overwrite value of cur
        logic      clear;
        logic      out_load;
        t_status   out_st;
        logic      out_pos;
        logic      out_item;
        logic      out_last;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [3:0] kind;
        logic       pos_zero;
        logic       head_nil;
        logic       cur_nil;
        logic       cnt_eq_tgt;
        logic       val_match;
        logic       next_nil;
        logic       read_cap;
        logic       free_nz;
        logic       fresh_ok;
        logic       out_free;
    } t_dp_sts;

endpackage

FILE: src/plp_datapath.sv
// Datapath of the pooled linked list engine: node memories, free stack,
// walk registers and the result register. Depends on plp_pkg.
module plp_datapath
    import plp_pkg::*;
#(
    parameter int POOL_SIZE   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [3:0]  i_s_tuser,
    input  logic [71:0] i_s_tdata,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [39:0] o_m_tdata,
    output logic        o_m_tlast
);

    localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int LW = IW + 1;
    localparam logic [LW-1:0] NIL = {LW{1'b1}};

    // Node storage
    logic signed [VALUE_WIDTH-1:0] value_mem [POOL_SIZE];
    logic [LW-1:0]                 link_mem  [POOL_SIZE];
    logic [IW-1:0]                 free_mem  [POOL_SIZE];

    // Command capture
    logic [3:0]         r_kind;
    logic [5:0]         r_pos;
    logic signed [31:0] r_val;
    logic signed [31:0] r_nval;

    // List control state
    logic [LW-1:0] r_head, r_cur, r_prev, r_cnt, r_free_cnt, r_fresh;
    logic [IW-1:0] r_new;

    // Registered memory read data
    logic signed [VALUE_WIDTH-1:0] r_rd_val;
    logic [LW-1:0]                 r_rd_next;
    logic [IW-1:0]                 r_rd_free;

    // Result register
    logic               r_out_valid;
    logic [1:0]         r_out_st;
    logic [5:0]         r_out_pos;
    logic signed [31:0] r_out_item;
    logic               r_out_last;

    logic signed [VALUE_WIDTH-1:0] w_val_st, w_nval_st;
    logic [6:0]    w_tgt;
    logic [LW-1:0] w_new_link, w_new_ext;
    logic          w_link_to_cur, w_out_free;

    assign w_val_st  = VALUE_WIDTH'(r_val);
    assign w_nval_st = VALUE_WIDTH'(r_nval);
    assign w_new_ext = LW'(r_new);
    assign w_link_to_cur = (r_cur != NIL);
    assign w_out_free = !r_out_valid || i_m_tready;

    // Walk target: predecessor for positional insert, head for head delete
    always_comb begin
        if (r_kind == K_DEL_HEAD) begin
            w_tgt = 7'd0;
        end else if (r_kind == K_INS_AT) begin
            w_tgt = {1'b0, r_pos} - 7'd1;
        end else begin
            w_tgt = {1'b0, r_pos};
        end
    end

    // Link of a new node
    always_comb begin
        case (i_cmd.nl_sel)
            NL_HEAD: w_new_link = r_head;
            NL_HIT:  w_new_link = r_rd_next;
            default: w_new_link = NIL;
        endcase
    end

    // Status toward controller
    always_comb begin
        o_sts.kind       = r_kind;
        o_sts.pos_zero   = (r_pos == 6'd0);
        o_sts.head_nil   = (r_head == NIL);
        o_sts.cur_nil    = (r_cur == NIL);
        o_sts.cnt_eq_tgt = (32'(r_cnt) == 32'(w_tgt));
        o_sts.val_match  = (r_rd_val == w_val_st);
        o_sts.next_nil   = (r_rd_next == NIL);
        o_sts.read_cap   = (32'(r_cnt) == MAX_RESULTS - 1);
        o_sts.free_nz    = (r_free_cnt != '0);
        o_sts.fresh_ok   = (32'(r_fresh) < POOL_SIZE);
        o_sts.out_free   = w_out_free;
    end

    // Command capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_kind <= i_s_tuser;
            r_pos  <= i_s_tdata[5:0];
            r_val  <= i_s_tdata[37:6];
            r_nval <= i_s_tdata[69:38];
        end
    end

    // Value memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new) begin
            value_mem[r_new] <= w_val_st;
        end else if (i_cmd.upd) begin
            value_mem[r_cur[IW-1:0]] <= w_nval_st;
        end
        if (i_cmd.rd_node) begin
            r_rd_val <= value_mem[r_cur[IW-1:0]];
        end
    end

    // Link memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new) begin
            link_mem[r_new] <= w_new_link;
        end else if (i_cmd.link_new && w_link_to_cur) begin
            link_mem[r_cur[IW-1:0]] <= w_new_ext;
        end else if (i_cmd.link_new && r_prev != NIL) begin
            link_mem[r_prev[IW-1:0]] <= w_new_ext;
        end else if (i_cmd.unlink && r_prev != NIL) begin
            link_mem[r_prev[IW-1:0]] <= r_rd_next;
        end
        if (i_cmd.rd_node) begin
            r_rd_next <= link_mem[r_cur[IW-1:0]];
        end
    end

    // Free stack memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.unlink) begin
            free_mem[r_free_cnt[IW-1:0]] <= r_cur[IW-1:0];
        end
        if (i_cmd.alloc_rd) begin
            r_rd_free <= free_mem[IW'(r_free_cnt - LW'(1))];
        end
    end

    // Walk and new-node registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_cur  <= r_head;
            r_prev <= NIL;
            r_cnt  <= '0;
        end else if (i_cmd.step) begin
            r_prev <= r_cur;
            r_cur  <= r_rd_next;
            r_cnt  <= r_cnt + LW'(1);
        end
        if (i_cmd.take_free) begin
            r_new <= r_rd_free;
        end else if (i_cmd.take_fresh) begin
            r_new <= r_fresh[IW-1:0];
        end
    end

    // Head, free count and fresh mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_head     <= NIL;
            r_free_cnt <= '0;
            r_fresh    <= '0;
        end else begin
            if (i_cmd.head_to_new) begin
                r_head <= w_new_ext;
            end else if (i_cmd.link_new && !w_link_to_cur && r_prev == NIL) begin
                r_head <= w_new_ext;
            end else if (i_cmd.unlink && r_prev == NIL) begin
                r_head <= r_rd_next;
            end
            if (i_cmd.alloc_rd) begin
                r_free_cnt <= r_free_cnt - LW'(1);
            end else if (i_cmd.unlink) begin
                r_free_cnt <= r_free_cnt + LW'(1);
            end
            if (i_cmd.take_fresh) begin
                r_fresh <= r_fresh + LW'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_st   <= i_cmd.out_st;
            r_out_pos  <= i_cmd.out_pos ? 6'(r_cnt) : 6'd0;
            r_out_item <= i_cmd.out_item ? 32'(r_rd_val) : 32'sd0;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_item, r_out_pos, r_out_st};
    assign o_m_tlast  = r_out_last;

    // Free nodes were all handed out from the fresh range
    a_free_le_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= r_fresh)
        else $error("free count exceeds fresh mark");

    // Head only names nodes already handed out
    a_head_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head != NIL |-> r_head < r_fresh)
        else $error("head names an unallocated node");

    // Pop never underflows the free stack
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc_rd |-> r_free_cnt != '0)
        else $error("free stack pop while empty");

endmodule

FILE: src/plp_ctrl.sv
// Controller of the pooled linked list engine: sequences allocation,
// list walks, link updates and result beats. Depends on plp_pkg.
module plp_ctrl
    import plp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_DISP     = 10'b0000000010,
        S_ALLOC    = 10'b0000000100,
        S_ALLOC_WT = 10'b0000001000,
        S_WALK     = 10'b0000010000,
        S_NODE     = 10'b0000100000,
        S_WR_NEW   = 10'b0001000000,
        S_LINK     = 10'b0010000000,
        S_ACT      = 10'b0100000000,
        S_RESP     = 10'b1000000000
    } t_state;

    t_state  r_state, n_state;
    t_status r_st, n_st;

    logic w_head_case, w_hit;

    assign o_s_tready = (r_state == S_IDLE);

    // Insert that places the new node at the head
    assign w_head_case = (i_sts.kind == K_INS_HEAD) ||
                         (i_sts.kind == K_INS_AT && (i_sts.pos_zero || i_sts.head_nil));

    // Walk stop condition per kind
    always_comb begin
        case (i_sts.kind)
            K_DEL_VALUE, K_UPD_VALUE, K_SEARCH: w_hit = i_sts.val_match;
            K_INS_TAIL, K_DEL_TAIL:             w_hit = i_sts.next_nil;
            default:                            w_hit = i_sts.cnt_eq_tgt;
        endcase
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        o_cmd   = '0;
        o_cmd.nl_sel = NL_NIL;
        o_cmd.out_st = r_st;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.kind)
                    K_INS_HEAD, K_INS_TAIL: begin
                        n_state = S_ALLOC;
                    end
                    K_INS_AT: begin
                        if (w_head_case) begin
                            n_state = S_ALLOC;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            n_state = S_WALK;
                        end
                    end
                    K_DEL_HEAD, K_DEL_TAIL, K_DEL_AT, K_DEL_VALUE,
                    K_UPD_AT, K_UPD_VALUE, K_SEARCH, K_READ: begin
                        o_cmd.walk_init = 1'b1;
                        n_state = S_WALK;
                    end
                    K_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_st    = ST_DONE;
                        n_state = S_RESP;
                    end
                    default: begin
                        n_st    = ST_MISS;
                        n_state = S_RESP;
                    end
                endcase
            end
            S_ALLOC: begin
                if (i_sts.free_nz) begin
                    o_cmd.alloc_rd = 1'b1;
                    n_state = S_ALLOC_WT;
                end else if (i_sts.fresh_ok) begin
                    o_cmd.take_fresh = 1'b1;
                    if (i_sts.kind == K_INS_TAIL) begin
                        o_cmd.walk_init = 1'b1;
                        n_state = S_WALK;
                    end else begin
                        n_state = S_WR_NEW;
                    end
                end else begin
                    n_st    = ST_FULL;
                    n_state = S_RESP;
                end
            end
            S_ALLOC_WT: begin
                o_cmd.take_free = 1'b1;
                if (i_sts.kind == K_INS_TAIL) begin
                    o_cmd.walk_init = 1'b1;
                    n_state = S_WALK;
                end else begin
                    n_state = S_WR_NEW;
                end
            end
            S_WALK: begin
                if (i_sts.cur_nil) begin
                    if (i_sts.kind == K_INS_TAIL) begin
                        n_state = S_WR_NEW;
                    end else begin
                        n_st    = ST_MISS;
                        n_state = S_RESP;
                    end
                end else begin
                    o_cmd.rd_node = 1'b1;
                    n_state = S_NODE;
                end
            end
            S_NODE: begin
                if (i_sts.kind == K_READ) begin
                    // one beat per element, held until the result register frees
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_st   = ST_DONE;
                        o_cmd.out_item = 1'b1;
                        o_cmd.out_last = i_sts.next_nil || i_sts.read_cap;
                        if (i_sts.next_nil || i_sts.read_cap) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.step = 1'b1;
                            n_state = S_WALK;
                        end
                    end
                end else if (w_hit) begin
                    if (i_sts.kind == K_INS_AT) begin
                        n_state = S_ALLOC;
                    end else if (i_sts.kind == K_INS_TAIL) begin
                        n_state = S_WR_NEW;
                    end else begin
                        n_state = S_ACT;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_WR_NEW: begin
                o_cmd.wr_new = 1'b1;
                if (w_head_case) begin
                    o_cmd.nl_sel      = NL_HEAD;
                    o_cmd.head_to_new = 1'b1;
                    n_st    = ST_DONE;
                    n_state = S_RESP;
                end else begin
                    o_cmd.nl_sel = (i_sts.kind == K_INS_AT) ? NL_HIT : NL_NIL;
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                o_cmd.link_new = 1'b1;
                n_st    = ST_DONE;
                n_state = S_RESP;
            end
            S_ACT: begin
                case (i_sts.kind)
                    K_DEL_HEAD, K_DEL_TAIL, K_DEL_AT, K_DEL_VALUE: o_cmd.unlink = 1'b1;
                    K_UPD_AT, K_UPD_VALUE:                         o_cmd.upd    = 1'b1;
                    default: ;
                endcase
                n_st    = ST_DONE;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_st   = r_st;
                    o_cmd.out_pos  = (i_sts.kind == K_SEARCH) && (r_st == ST_DONE);
                    o_cmd.out_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_MISS;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    // A result beat is only loaded into a free result register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over a pending beat");

    // A command is taken only from idle and then dispatched
    a_cap_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cap |=> r_state == S_DISP)
        else $error("capture not followed by dispatch");

    // Walk reads only a real node
    a_rd_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_node |-> !i_sts.cur_nil)
        else $error("node read at nil");

endmodule

FILE: src/pooled_linked_list_engine.sv
// Top level of the pooled linked list engine: joins the controller and
// the datapath. Depends on plp_pkg, plp_ctrl and plp_datapath.
//
//  Channel | Direction | Beat contents
//  s       | in        | tuser: kind[3:0]; tdata: position, value, new_value
//  m       | out       | tdata: status, found_position, item_value; tlast: last
//
// One command at a time. A command is captured and then dispatched; each
// list node visited is read from the registered node memory, then decided
// on, and an allocation from the free stack adds a wait for the popped
// entry. Read emits one beat per node as it is walked. Reset is synchronous
// and empties the list at once; node memories need no clearing. A stalled
// output holds the controller in place; no beat is dropped.
module pooled_linked_list_engine
    import plp_pkg::*;
#(
    parameter int POOL_SIZE   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,  // position[5:0], value[37:6], new_value[69:38], zeros
    input  logic [3:0]  i_s_tuser,  // kind[3:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // status[1:0], found_position[7:2], item_value[39:8]
    output logic        o_m_tlast
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    plp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    plp_datapath #(
        .POOL_SIZE   (POOL_SIZE),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
